FILE: hdl/tlsf_pkg.sv
// Shared types and codes for the TLSF size-class bitmap engine.
// No dependencies.
package tlsf_pkg;

   // Request type codes
   localparam logic [1:0] REQ_SEARCH  = 2'd0;
   localparam logic [1:0] REQ_INSERT  = 2'd1;
   localparam logic [1:0] REQ_EMPTIED = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_MAP,
      ST_EVAL,
      ST_RESCAN
   } state_type;

   // Index of the highest set bit, 0 when the value is zero.
   function automatic logic [5:0] msb33(input logic [32:0] v);
      logic [5:0] n;
      n = '0;
      for (int i = 0; i < 33; i++) begin
         if (v[i]) begin
            n = 6'(i);
         end
      end
      return n;
   endfunction

   // Index of the lowest set bit, 0 when the word is zero.
   function automatic logic [4:0] lsb32(input logic [31:0] v);
      logic [4:0] n;
      n = '0;
      for (int i = 31; i >= 0; i--) begin
         if (v[i]) begin
            n = 5'(i);
         end
      end
      return n;
   endfunction

endpackage

FILE: hdl/tlsf_req_if.sv
// Request channel of the TLSF bitmap engine: valid/ready plus payload.
// No dependencies.
interface tlsf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] req_size;

   modport source (output valid, output req_type, output req_size, input ready);
   modport sink   (input valid, input req_type, input req_size, output ready);
endinterface

FILE: hdl/tlsf_rsp_if.sv
// Response channel of the TLSF bitmap engine: valid/ready plus payload.
// No dependencies.
interface tlsf_rsp_if;
   logic       valid;
   logic       ready;
   logic       found;
   logic [3:0] class_first;
   logic [3:0] class_second;

   modport source (output valid, output found, output class_first, output class_second,
                   input ready);
   modport sink   (input valid, input found, input class_first, input class_second,
                   output ready);
endinterface

FILE: hdl/tlsf_size_class_bitmap_engine.sv
// TLSF two-level availability bitmaps: size-to-class mapping, search, update.
// Depends on tlsf_pkg, tlsf_req_if, tlsf_rsp_if.
//
// Usage:
//   req_chan carries req_type (search / insert / emptied) and req_size.
//   rsp_chan returns one transfer per request: found, class_first, class_second.
//   A request is taken only while the engine is idle; one request is in work
//   at a time. A request passes the round, map and read, and evaluate steps;
//   the output register loads at the end of evaluate, or after a further
//   rescan step when a search misses its own first level and has to read
//   the second-level word of a higher first level.
//   No new request is taken before the previous one is finished, with the
//   read-modify-write of the second-level word memory (registered read)
//   behind the two mapping steps.
//   The response sits in an output register: while the receiver stalls the
//   next request is still accepted and worked up to its final step, where it
//   waits for the register to free up.
//   Reset (synchronous) clears the first-level word and the per-entry valid
//   bits of the second-level memory, so every class reads as empty; no
//   clearing pass is needed.
module tlsf_size_class_bitmap_engine #(
   parameter int unsigned SL_LOG2           = 4,
   parameter int unsigned NUM_FIRST_LEVELS  = 16,
   parameter int unsigned FIRST_LEVEL_START = 5,
   parameter int unsigned MIN_BLOCK_SIZE    = 32,
   parameter int unsigned MAX_ALLOC_SIZE    = 32'd2097151
) (
   input logic           clock,
   input logic           reset,
   tlsf_req_if.sink      req_chan,
   tlsf_rsp_if.source    rsp_chan
);

   localparam int unsigned NUM_LISTS = 1 << SL_LOG2;
   localparam int unsigned SL_W      = SL_LOG2;
   localparam int unsigned FL_W      = $clog2(NUM_FIRST_LEVELS);

   tlsf_pkg::state_type state_ff, state_in;

   logic [1:0]                  type_ff, type_in;
   logic [32:0]                 size_ff, size_in;
   logic                        small_ff, small_in;
   logic [FL_W-1:0]             fl_ff, fl_in;
   logic [SL_W-1:0]             sl_ff, sl_in;
   logic [NUM_FIRST_LEVELS-1:0] fl_bits_ff, fl_bits_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       found_ff, found_in;
   logic [3:0] cf_ff, cf_in;
   logic [3:0] cs_ff, cs_in;

   // second-level word memory
   logic [NUM_LISTS-1:0]        sl_mem [NUM_FIRST_LEVELS];
   logic [NUM_FIRST_LEVELS-1:0] vld_ff;
   logic [NUM_LISTS-1:0]        rd_data_ff;
   logic                        rd_vld_ff;
   logic                        rd_en;
   logic [FL_W-1:0]             rd_addr;
   logic                        wr_en;
   logic [NUM_LISTS-1:0]        wr_data;

   logic out_free;
   logic accept;
   logic finish;

   // datapath
   logic [5:0]            msb_r;
   logic [32:0]           round_inc;
   logic [5:0]            msb_v;
   logic [6:0]            f_idx;
   logic [32+SL_W:0]      sl_shift;
   logic [FL_W-1:0]       map_fl;
   logic [SL_W-1:0]       map_sl;
   logic [NUM_LISTS-1:0]  word;
   logic [NUM_LISTS-1:0]  sl_mask;
   logic [NUM_LISTS-1:0]  sl_hits;
   logic [NUM_LISTS-1:0]  sl_onehot;
   logic [NUM_LISTS-1:0]  word_set;
   logic [NUM_LISTS-1:0]  word_clr;
   logic [NUM_FIRST_LEVELS-1:0] fl_mask;
   logic [NUM_FIRST_LEVELS-1:0] fl_hits;
   logic [NUM_FIRST_LEVELS-1:0] fl_onehot;
   logic [FL_W-1:0]       hit_fl;
   logic [SL_W-1:0]       hit_sl;
   logic [SL_W-1:0]       word_lsb;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign accept   = req_chan.valid && req_chan.ready;

   assign req_chan.ready        = (state_ff == tlsf_pkg::ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.found        = found_ff;
   assign rsp_chan.class_first  = cf_ff;
   assign rsp_chan.class_second = cs_ff;

   // rounding step for searches
   always_comb begin
      msb_r     = tlsf_pkg::msb33(size_ff);
      round_inc = (33'd1 << (msb_r - 6'(SL_LOG2))) - 33'd1;
   end

   // size to class mapping
   always_comb begin
      msb_v    = tlsf_pkg::msb33(size_ff);
      f_idx    = 7'(msb_v) - 7'(FIRST_LEVEL_START);
      sl_shift = {size_ff, {SL_W{1'b0}}} >> msb_v;
      map_fl   = '0;
      map_sl   = '0;
      if (small_ff) begin
         map_fl = '0;
         map_sl = '0;
      end else if (size_ff > 33'(MAX_ALLOC_SIZE)) begin
         map_fl = FL_W'(NUM_FIRST_LEVELS - 1);
         map_sl = SL_W'(NUM_LISTS - 1);
      end else if (size_ff < 33'(MIN_BLOCK_SIZE)) begin
         map_fl = '0;
         map_sl = '0;
      end else if (msb_v < 6'(FIRST_LEVEL_START)) begin
         map_fl = '0;
         map_sl = '0;
      end else if (f_idx >= 7'(NUM_FIRST_LEVELS)) begin
         map_fl = FL_W'(NUM_FIRST_LEVELS - 1);
         map_sl = SL_W'(NUM_LISTS - 1);
      end else begin
         map_fl = f_idx[FL_W-1:0];
         map_sl = sl_shift[SL_W-1:0];
      end
   end

   // evaluation of the fetched second-level word
   always_comb begin
      word = rd_vld_ff ? rd_data_ff : '0;
      for (int i = 0; i < NUM_LISTS; i++) begin
         sl_mask[i] = (SL_W'(i) >= sl_ff);
      end
      for (int i = 0; i < NUM_FIRST_LEVELS; i++) begin
         fl_mask[i] = (FL_W'(i) > fl_ff);
      end
      sl_hits   = word & sl_mask;
      fl_hits   = fl_bits_ff & fl_mask;
      hit_sl    = SL_W'(tlsf_pkg::lsb32(32'(sl_hits)));
      hit_fl    = FL_W'(tlsf_pkg::lsb32(32'(fl_hits)));
      word_lsb  = SL_W'(tlsf_pkg::lsb32(32'(word)));
      sl_onehot = NUM_LISTS'(1) << sl_ff;
      fl_onehot = NUM_FIRST_LEVELS'(1) << fl_ff;
      word_set  = word | sl_onehot;
      word_clr  = word & ~sl_onehot;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tlsf_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = tlsf_pkg::ST_ROUND;
            end
         end
         tlsf_pkg::ST_ROUND: state_in = tlsf_pkg::ST_MAP;
         tlsf_pkg::ST_MAP:   state_in = tlsf_pkg::ST_EVAL;
         tlsf_pkg::ST_EVAL: begin
            if (type_ff == tlsf_pkg::REQ_SEARCH && sl_hits == '0 && fl_hits != '0) begin
               state_in = tlsf_pkg::ST_RESCAN;
            end else if (out_free) begin
               state_in = tlsf_pkg::ST_IDLE;
            end
         end
         tlsf_pkg::ST_RESCAN: begin
            if (out_free) begin
               state_in = tlsf_pkg::ST_IDLE;
            end
         end
         default: state_in = tlsf_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      type_in    = type_ff;
      size_in    = size_ff;
      small_in   = small_ff;
      fl_in      = fl_ff;
      sl_in      = sl_ff;
      fl_bits_in = fl_bits_ff;
      rd_en      = 1'b0;
      rd_addr    = fl_ff;
      wr_en      = 1'b0;
      wr_data    = word;
      finish     = 1'b0;
      found_in   = 1'b0;
      cf_in      = 4'(fl_ff);
      cs_in      = 4'(sl_ff);
      unique case (state_ff)
         tlsf_pkg::ST_IDLE: begin
            if (accept) begin
               type_in = req_chan.req_type;
               size_in = {1'b0, req_chan.req_size};
            end
         end
         tlsf_pkg::ST_ROUND: begin
            small_in = (type_ff == tlsf_pkg::REQ_SEARCH) &&
                       (size_ff < 33'(MIN_BLOCK_SIZE));
            if (type_ff == tlsf_pkg::REQ_SEARCH && msb_r >= 6'(SL_LOG2)) begin
               size_in = size_ff + round_inc;
            end
         end
         tlsf_pkg::ST_MAP: begin
            fl_in   = map_fl;
            sl_in   = map_sl;
            rd_en   = 1'b1;
            rd_addr = map_fl;
         end
         tlsf_pkg::ST_EVAL: begin
            case (type_ff)
               tlsf_pkg::REQ_SEARCH: begin
                  if (sl_hits != '0) begin
                     finish   = out_free;
                     found_in = 1'b1;
                     cs_in    = 4'(hit_sl);
                  end else if (fl_hits != '0) begin
                     // move on to the next non-empty first level
                     fl_in   = hit_fl;
                     rd_en   = 1'b1;
                     rd_addr = hit_fl;
                  end else begin
                     finish = out_free;
                  end
               end
               tlsf_pkg::REQ_INSERT: begin
                  finish   = out_free;
                  found_in = 1'b1;
                  wr_en    = out_free;
                  wr_data  = word_set;
                  if (out_free) begin
                     fl_bits_in = fl_bits_ff | fl_onehot;
                  end
               end
               tlsf_pkg::REQ_EMPTIED: begin
                  finish   = out_free;
                  found_in = 1'b1;
                  wr_en    = out_free;
                  wr_data  = word_clr;
                  if (out_free && word_clr == '0) begin
                     fl_bits_in = fl_bits_ff & ~fl_onehot;
                  end
               end
               default: begin
                  finish = out_free;
                  cf_in  = '0;
                  cs_in  = '0;
               end
            endcase
         end
         tlsf_pkg::ST_RESCAN: begin
            finish   = out_free;
            found_in = 1'b1;
            cs_in    = 4'(word_lsb);
         end
         default: begin
            finish = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = finish ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlsf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fl_bits_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fl_bits_ff   <= fl_bits_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff  <= type_in;
      size_ff  <= size_in;
      small_ff <= small_in;
      fl_ff    <= fl_in;
      sl_ff    <= sl_in;
      if (finish) begin
         found_ff <= found_in;
         cf_ff    <= cf_in;
         cs_ff    <= cs_in;
      end
   end

   // per-entry valid bits: an entry never written reads as empty
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[rd_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   // writes use the address of the word fetched for this request
   always_ff @(posedge clock) begin
      if (wr_en) begin
         sl_mem[rd_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= sl_mem[rd_addr];
      end
   end

endmodule
